// ===== design/cst_pkg.sv =====
package cst_pkg;

  localparam int unsigned MAX_SIZE   = 4096;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned QUO_W      = 31;

  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_FILL   = 3'd2;
  localparam logic [2:0] REQ_PEAK   = 3'd3;
  localparam logic [2:0] REQ_NORM   = 3'd4;
  localparam logic [2:0] REQ_RESIZE = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [QUO_W-1:0] ONE_Q16 = QUO_W'(65536);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_WR, S_RD, S_FILL, S_CLR, S_PK_RD, S_PK_CMP,
    S_NM_START, S_NM_RD, S_NM_MUL, S_NM_DIVI, S_NM_DIV, S_NM_WR, S_FIN, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    WD_VAL, WD_ZERO, WD_QUO
  } wsel_e;

  typedef struct packed {
    logic  load_req;
    logic  start_idx;
    logic  start_zero;
    logic  start_grow;
    logic  idx_inc;
    logic  ram_we;
    wsel_e wsel;
    logic  peak_clr;
    logic  peak_upd;
    logic  mul_load;
    logic  div_init;
    logic  div_step;
    logic  res_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       empty;
    logic       idx_last;
    logic       peak_zero;
    logic       div_last;
    logic       grow;
  } stat_t;

endpackage

// ===== design/cst_ram.sv =====
module cst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cst_ctrl.sv =====
module cst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  cst_pkg::stat_t stat_i,
  output cst_pkg::cmd_t  cmd_o
);
  import cst_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_START;
      S_START: begin
        case (stat_i.req)
          REQ_WRITE:  state_d = stat_i.empty ? S_FIN : S_WR;
          REQ_READ:   state_d = stat_i.empty ? S_FIN : S_RD;
          REQ_FILL:   state_d = stat_i.empty ? S_FIN : S_FILL;
          REQ_PEAK,
          REQ_NORM:   state_d = stat_i.empty ? S_FIN : S_PK_RD;
          REQ_RESIZE: state_d = stat_i.grow ? S_CLR : S_FIN;
          default:    state_d = S_FIN;
        endcase
      end
      S_WR:     state_d = S_FIN;
      S_RD:     state_d = S_FIN;
      S_FILL:   if (stat_i.idx_last) state_d = S_FIN;
      S_CLR:    if (stat_i.idx_last) state_d = S_FIN;
      S_PK_RD:  state_d = S_PK_CMP;
      S_PK_CMP: begin
        if (!stat_i.idx_last) state_d = S_PK_RD;
        else if (stat_i.req == REQ_NORM) state_d = S_NM_START;
        else state_d = S_FIN;
      end
      S_NM_START: state_d = stat_i.peak_zero ? S_FIN : S_NM_RD;
      S_NM_RD:    state_d = S_NM_MUL;
      S_NM_MUL:   state_d = S_NM_DIVI;
      S_NM_DIVI:  state_d = S_NM_DIV;
      S_NM_DIV:   if (stat_i.div_last) state_d = S_NM_WR;
      S_NM_WR:    state_d = stat_i.idx_last ? S_FIN : S_NM_RD;
      S_FIN:      state_d = S_OUT;
      S_OUT:      if (!out_stall_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.wsel  = WD_VAL;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      S_START: begin
        cmd_o.start_idx  = stat_i.req inside {REQ_WRITE, REQ_READ, REQ_FILL};
        cmd_o.start_zero = stat_i.req inside {REQ_PEAK, REQ_NORM};
        cmd_o.peak_clr   = 1'b1;
        cmd_o.start_grow = (stat_i.req == REQ_RESIZE);
      end
      S_WR: cmd_o.ram_we = 1'b1;
      S_FILL: begin
        cmd_o.ram_we  = 1'b1;
        cmd_o.idx_inc = !stat_i.idx_last;
      end
      S_CLR: begin
        cmd_o.ram_we  = 1'b1;
        cmd_o.wsel    = WD_ZERO;
        cmd_o.idx_inc = !stat_i.idx_last;
      end
      S_PK_CMP: begin
        cmd_o.peak_upd = 1'b1;
        cmd_o.idx_inc  = !stat_i.idx_last;
      end
      S_NM_START: cmd_o.start_zero = 1'b1;
      S_NM_MUL:   cmd_o.mul_load = 1'b1;
      S_NM_DIVI:  cmd_o.div_init = 1'b1;
      S_NM_DIV:   cmd_o.div_step = 1'b1;
      S_NM_WR: begin
        cmd_o.ram_we  = 1'b1;
        cmd_o.wsel    = WD_QUO;
        cmd_o.idx_inc = !stat_i.idx_last;
      end
      S_FIN: cmd_o.res_load = 1'b1;
      S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== design/cst_dp.sv =====
module cst_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [2:0]                       req_type_i,
  input  logic signed [cst_pkg::DATA_W-1:0] position_i,
  input  logic signed [cst_pkg::DATA_W-1:0] sample_in_i,
  input  cst_pkg::cmd_t                    cmd_i,
  output cst_pkg::stat_t                   stat_o,
  output logic signed [cst_pkg::DATA_W-1:0] read_value_o,
  output logic [30:0]                      peak_value_o,
  output logic [cst_pkg::SIZE_W-1:0]       size_now_o,
  output logic [1:0]                       status_o
);
  import cst_pkg::*;

  localparam int unsigned AW = ADDR_W;

  logic [2:0]        req_q;
  logic [DATA_W-1:0] pos_q, val_q;
  logic [SIZE_W-1:0] used_q;
  logic [AW-1:0]     idx_q;
  logic [DATA_W-1:0] peak_q;
  logic [61:0]       prod_q;
  logic              neg_q;
  logic [DATA_W-1:0] rem_q;
  logic [QUO_W-1:0]  quo_q, lo_q;
  logic [4:0]        bit_q;
  logic [DATA_W-1:0] rd_q;
  logic [30:0]       pk_q;
  logic [1:0]        st_q;

  logic [DATA_W-1:0] rdata, wdata, mag, abs_rd;
  logic [AW-1:0]     cidx;
  logic [SIZE_W-1:0] nsz, lim;
  logic              sat;
  logic [QUO_W-1:0]  target;
  logic [DATA_W:0]   trial;
  logic              qbit;
  logic [DATA_W-1:0] quo_s;

  // request latch and size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= '0;
      used_q <= '0;
    end else begin
      if (cmd_i.load_req) req_q <= req_type_i;
      if (cmd_i.res_load && req_q == REQ_RESIZE) used_q <= nsz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      pos_q <= position_i;
      val_q <= sample_in_i;
    end
  end

  // clamped index and new size
  always_comb begin
    if (pos_q[DATA_W-1]) cidx = '0;
    else if (pos_q[DATA_W-2:0] >= (DATA_W-1)'(used_q)) cidx = AW'(used_q - SIZE_W'(1));
    else cidx = pos_q[AW-1:0];
    sat = 1'b0;
    if (pos_q[DATA_W-1]) nsz = '0;
    else if (pos_q[DATA_W-2:0] > (DATA_W-1)'(MAX_SIZE)) begin
      nsz = SIZE_W'(MAX_SIZE);
      sat = 1'b1;
    end else nsz = pos_q[SIZE_W-1:0];
    lim = (req_q == REQ_RESIZE) ? nsz : used_q;
  end

  // walk index
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_idx) idx_q <= cidx;
    else if (cmd_i.start_zero) idx_q <= '0;
    else if (cmd_i.start_grow) idx_q <= AW'(used_q);
    else if (cmd_i.idx_inc) idx_q <= idx_q + AW'(1);
  end

  // sample memory
  always_comb begin
    case (cmd_i.wsel)
      WD_VAL:  wdata = val_q;
      WD_ZERO: wdata = '0;
      WD_QUO:  wdata = quo_s;
      default: wdata = '0;
    endcase
  end

  cst_ram #(.Width(DATA_W), .Depth(MAX_SIZE)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // peak tracking
  assign abs_rd = rdata[DATA_W-1] ? (~rdata + DATA_W'(1)) : rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.peak_clr) peak_q <= '0;
    else if (cmd_i.peak_upd && abs_rd > peak_q) peak_q <= abs_rd;
  end

  // scale: magnitude times target, then restoring divide by peak
  assign target = (val_q[DATA_W-1] || val_q == '0) ? ONE_Q16 : val_q[QUO_W-1:0];
  assign mag    = abs_rd;
  assign trial  = {rem_q, lo_q[QUO_W-1]};
  assign qbit   = trial >= {1'b0, peak_q};
  assign quo_s  = neg_q ? (~{1'b0, quo_q} + DATA_W'(1)) : {1'b0, quo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= 62'(mag * target);
      neg_q  <= rdata[DATA_W-1];
    end
    if (cmd_i.div_init) begin
      rem_q <= {1'b0, prod_q[61:31]};
      lo_q  <= prod_q[30:0];
      bit_q <= 5'd30;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? DATA_W'(trial - {1'b0, peak_q}) : trial[DATA_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], qbit};
      lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
      bit_q <= bit_q - 5'd1;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      rd_q <= (req_q == REQ_READ && used_q != '0) ? rdata : '0;
      pk_q <= (req_q inside {REQ_PEAK, REQ_NORM}) ?
              (peak_q[DATA_W-1] ? '1 : peak_q[30:0]) : '0;
      if ((req_q inside {REQ_WRITE, REQ_READ, REQ_FILL}) && used_q == '0)
        st_q <= ST_EMPTY;
      else if (req_q == REQ_RESIZE && sat) st_q <= ST_SAT;
      else st_q <= ST_DONE;
    end
  end

  assign read_value_o = rd_q;
  assign peak_value_o = pk_q;
  assign size_now_o   = used_q;
  assign status_o     = st_q;

  assign stat_o.req       = req_q;
  assign stat_o.empty     = (used_q == '0);
  assign stat_o.idx_last  = ((SIZE_W'(idx_q) + SIZE_W'(1)) >= lim);
  assign stat_o.peak_zero = (peak_q == '0);
  assign stat_o.div_last  = (bit_q == '0);
  assign stat_o.grow      = (nsz > used_q);

endmodule

// ===== design/clamped_sample_table.sv =====
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | req_type_i, position_i, sample_in_i
// out     | out_valid_o| out_stall_i | read_value_o, peak_value_o, size_now_o, status_o
//
// one request at a time; write or read: start, access, finish, then output transfer
// fill and resize growth write one entry per cycle, peak reads then compares each used entry
// normalize then rescales each used entry: read, multiply, bit-serial divide, write
// reset clears the used size only; entries are zeroed as resize brings them into use
// a held output keeps the input stalled until the result transfer completes
module clamped_sample_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        req_type_i,
  input  logic signed [cst_pkg::DATA_W-1:0] position_i,
  input  logic signed [cst_pkg::DATA_W-1:0] sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cst_pkg::DATA_W-1:0] read_value_o,
  output logic [30:0]                       peak_value_o,
  output logic [cst_pkg::SIZE_W-1:0]        size_now_o,
  output logic [1:0]                        status_o
);
  import cst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // control sequencer
  cst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // table, scan and scaling datapath
  cst_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .sample_in_i  (sample_in_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .read_value_o (read_value_o),
    .peak_value_o (peak_value_o),
    .size_now_o   (size_now_o),
    .status_o     (status_o)
  );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  // request codes the block does not implement
  localparam logic [2:0] REQ_UNUSED_A = 3'd6;
  localparam logic [2:0] REQ_UNUSED_B = 3'd7;

  localparam int unsigned NUM_RANDOM  = 1520;
  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 60;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [30:0]              peak_value;
    logic [SIZE_W-1:0]        size_now;
    logic [1:0]               status;
  } table_result_t;

  typedef struct packed {
    logic [2:0]               req;
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] val;
    logic                     typed;
    table_result_t            res;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [2:0]               req_type_i;
  logic signed [DATA_W-1:0] position_i;
  logic signed [DATA_W-1:0] sample_in_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] read_value_o;
  logic [30:0]              peak_value_o;
  logic [SIZE_W-1:0]        size_now_o;
  logic [1:0]               status_o;

  clamped_sample_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .peak_value_o (peak_value_o),
    .size_now_o   (size_now_o),
    .status_o     (status_o)
  );

  // shadow copy of the table
  int            shadow_mem [MAX_SIZE];
  int unsigned   shadow_used;
  table_result_t pending_results [$];
  int unsigned   mismatch_cnt;
  int unsigned   cycle_cnt;
  logic          rx_quiet;
  logic          hold_req;
  logic          tx_quiet;

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_slot(longint pos);
    if (pos < 0) return 0;
    if (pos >= longint'(shadow_used)) return shadow_used - 1;
    return int'(pos);
  endfunction

  // expected result of one request, updating the shadow table
  function automatic table_result_t apply_request(logic [2:0] req, int pos, int val);
    table_result_t r;
    longint        pk;
    longint        tgt;
    longint        q;
    longint        n;
    r = '0;
    pk = 0;
    case (req)
      REQ_WRITE, REQ_READ, REQ_FILL: begin
        if (shadow_used == 0) begin
          r.status = ST_EMPTY;
        end else if (req == REQ_WRITE) begin
          shadow_mem[clamp_slot(pos)] = val;
        end else if (req == REQ_READ) begin
          r.read_value = shadow_mem[clamp_slot(pos)];
        end else begin
          for (int i = clamp_slot(pos); i < shadow_used; i++) shadow_mem[i] = val;
        end
      end
      REQ_PEAK, REQ_NORM: begin
        for (int i = 0; i < shadow_used; i++) begin
          longint a;
          a = shadow_mem[i];
          if (a < 0) a = -a;
          if (a > pk) pk = a;
        end
        r.peak_value = (pk > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : pk[30:0];
        if (req == REQ_NORM && pk > 0) begin
          tgt = (val <= 0) ? 64'd65536 : longint'(val);
          for (int i = 0; i < shadow_used; i++) begin
            q = (longint'(shadow_mem[i]) * tgt) / pk;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            shadow_mem[i] = int'(q);
          end
        end
      end
      REQ_RESIZE: begin
        n = (pos < 0) ? 64'sd0 : longint'(pos);
        if (n > MAX_SIZE) begin
          n = MAX_SIZE;
          r.status = ST_SAT;
        end
        for (longint i = shadow_used; i < n; i++) shadow_mem[i] = 0;
        shadow_used = 32'(n);
      end
      default: ;
    endcase
    r.size_now = shadow_used[SIZE_W-1:0];
    return r;
  endfunction

  // one request transfer, then optional idle cycles
  task automatic send_request(logic [2:0] req, int pos, int val, logic typed,
                              table_result_t typed_res);
    table_result_t r;
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    position_i  <= pos;
    sample_in_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_request(req, pos, val);
    pending_results.push_back(typed ? typed_res : r);
    if (!tx_quiet && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    table_result_t exp_r;
    int unsigned   hold_left;
    bit            hold_seen;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result transfer at cycle %0d", cycle_cnt);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.read_value !== read_value_o || exp_r.peak_value !== peak_value_o ||
            exp_r.size_now !== size_now_o || exp_r.status !== status_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch cycle %0d: exp rd=%h pk=%h sz=%0d st=%0d got rd=%h pk=%h sz=%0d st=%0d",
                     cycle_cnt, exp_r.read_value, exp_r.peak_value, exp_r.size_now,
                     exp_r.status, read_value_o, peak_value_o, size_now_o, status_o);
        end
      end
    end
    // single long hold-off, started once
    if (hold_req && !hold_seen) begin
      hold_left = HOLD_CYCLES;
      hold_seen = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !rx_quiet && ($urandom_range(0, 99) < 22);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("clamped_sample_table regression: fail");
      $finish;
    end
  end

  // directed rows
  stim_row_t dir_rows [] = '{
    '{REQ_READ,    5,            32'h1234,     1'b1, '{0, 0, 0, ST_EMPTY}},
    '{REQ_WRITE,   0,            32'h7,        1'b1, '{0, 0, 0, ST_EMPTY}},
    '{REQ_FILL,    0,            32'h7,        1'b1, '{0, 0, 0, ST_EMPTY}},
    '{REQ_PEAK,    0,            0,            1'b1, '{0, 0, 0, ST_DONE}},
    '{REQ_NORM,    0,            32'h10000,    1'b1, '{0, 0, 0, ST_DONE}},
    '{REQ_RESIZE,  -5,           0,            1'b1, '{0, 0, 0, ST_DONE}},
    '{REQ_RESIZE,  5000,         0,            1'b1, '{0, 0, 4096, ST_SAT}},
    '{REQ_PEAK,    0,            0,            1'b1, '{0, 0, 4096, ST_DONE}},
    '{REQ_FILL,    32'h7FFFFFFF, 32'h55,       1'b0, '0},
    '{REQ_RESIZE,  8,            0,            1'b1, '{0, 0, 8, ST_DONE}},
    '{REQ_WRITE,   32'h80000000, 32'h80000000, 1'b1, '{0, 0, 8, ST_DONE}},
    '{REQ_WRITE,   100,          32'h7FFFFFFF, 1'b1, '{0, 0, 8, ST_DONE}},
    '{REQ_READ,    -7,           0,            1'b1, '{32'h80000000, 0, 8, ST_DONE}},
    '{REQ_READ,    99,           0,            1'b1, '{32'h7FFFFFFF, 0, 8, ST_DONE}},
    '{REQ_PEAK,    0,            0,            1'b1, '{0, 31'h7FFFFFFF, 8, ST_DONE}},
    '{REQ_NORM,    0,            0,            1'b0, '0},
    '{REQ_READ,    0,            0,            1'b0, '0},
    '{REQ_WRITE,   3,            32'hFFFF0000, 1'b0, '0},
    '{REQ_NORM,    0,            -5,           1'b0, '0},
    '{REQ_NORM,    0,            32'h7FFFFFFF, 1'b0, '0},
    '{REQ_READ,    3,            0,            1'b0, '0},
    '{REQ_FILL,    -1,           0,            1'b1, '{0, 0, 8, ST_DONE}},
    '{REQ_NORM,    0,            32'h20000,    1'b1, '{0, 0, 8, ST_DONE}},
    '{REQ_UNUSED_A, 1,           1,            1'b1, '{0, 0, 8, ST_DONE}},
    '{REQ_UNUSED_B, 1,           1,            1'b1, '{0, 0, 8, ST_DONE}}
  };

  function automatic int pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom;
    if (sel < 85) return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
    case ($urandom_range(0, 4))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic int pick_index();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(0, shadow_used + 2);
    if (sel < 80) return -int'($urandom_range(1, 32'h7FFFFFFF));
    return $urandom;
  endfunction

  // stimulus
  initial begin
    logic [2:0] req;
    int         pos;
    int         val;
    int         sel;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_READ;
    position_i   = '0;
    sample_in_i  = '0;
    out_stall_i  = 1'b0;
    cycle_cnt    = 0;
    mismatch_cnt = 0;
    rx_quiet     = 1'b0;
    tx_quiet     = 1'b0;
    hold_req     = 1'b0;
    shadow_used  = 0;
    foreach (shadow_mem[i]) shadow_mem[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].pos, dir_rows[i].val,
                   dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // stretch with no idling on either side
      tx_quiet <= (n >= 300 && n < 500);
      rx_quiet <= (n >= 300 && n < 500);
      // long receiver hold-off while requests keep coming
      hold_req <= (n == 700);
      // sender pause until everything has drained
      if (n == 1000) begin
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      sel = $urandom_range(0, 99);
      pos = pick_index();
      val = pick_value();
      if (sel < 30) req = REQ_WRITE;
      else if (sel < 60) req = REQ_READ;
      else if (sel < 69) req = REQ_FILL;
      else if (sel < 76) req = REQ_PEAK;
      else if (sel < 84) req = REQ_NORM;
      else if (sel < 97) req = REQ_RESIZE;
      else req = ($urandom_range(0, 1) != 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
      if (req == REQ_NORM) begin
        // normalize is slow, keep it to small tables
        if (shadow_used > 64) req = REQ_PEAK;
        else if ($urandom_range(0, 3) != 0) val = $urandom_range(1, 32'h00200000);
      end
      if (req == REQ_RESIZE) begin
        sel = $urandom_range(0, 99);
        if (sel < 85) pos = $urandom_range(0, 48);
        else if (sel < 90) pos = -int'($urandom_range(1, 32'h7FFFFFFF));
        else if (sel < 94) pos = $urandom_range(MAX_SIZE + 1, 32'h7FFFFFFF);
        else if (sel < 95) pos = MAX_SIZE;
        else pos = $urandom_range(100, 600);
      end
      send_request(req, pos, val, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("clamped_sample_table regression: pass");
    end else begin
      $display("clamped_sample_table regression: fail");
    end
    $finish;
  end

endmodule
